### hdl/usvg_pkg.sv
// Shared types, constants and step functions of the UV-sphere vertex generator.
// No dependencies; every other file imports this package.
`default_nettype none

package usvg_pkg;

    // Field widths
    localparam int CNT_W  = 11;
    localparam int RAD_W  = 16;
    localparam int TEX_W  = 17;
    localparam int POS_W  = 17;
    localparam int NRM_W  = 16;
    localparam int XY_W   = 33;
    localparam int Z_W    = 33;
    localparam int UNIT_W = 32;

    // One quotient bit per divider cell
    localparam int DIV_STEPS = 17;

    // Defaults for the top-level parameters
    localparam int MAX_DIVISIONS_DEF = 1024;
    localparam int CORDIC_STEPS_DEF  = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_SECTOR_COUNT  = 2'd0;
    localparam logic [1:0] CFG_STACK_COUNT   = 2'd1;
    localparam logic [1:0] CFG_SPHERE_RADIUS = 2'd2;

    // CORDIC start vector (gain compensated) and arctangents in Q0.32 turns
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // One lane of the restoring divider: partial remainder and shifting
    // numerator bits, which turn into quotient bits from the bottom up
    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [TEX_W-1:0] nq;
    } t_div_lane;

    typedef struct packed {
        logic      valid;
        logic      in_range;
        t_div_lane stk;
        t_div_lane sec;
    } t_div_beat;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             q;
    } t_cordic_lane;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic [TEX_W-1:0] tex_s;
        logic [TEX_W-1:0] tex_t;
        t_cordic_lane     u;
        t_cordic_lane     v;
    } t_cordic_beat;

    // One restoring division step
    function automatic t_div_lane div_step(input t_div_lane l, input logic [CNT_W-1:0] d);
        logic [CNT_W:0] t;
        t_div_lane      r;
        t = {l.rem, l.nq[TEX_W-1]};
        if (t >= {1'b0, d}) begin
            r.rem = CNT_W'(t - {1'b0, d});
            r.nq  = {l.nq[TEX_W-2:0], 1'b1};
        end else begin
            r.rem = t[CNT_W-1:0];
            r.nq  = {l.nq[TEX_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Split a phase into quadrant and residual; start the CORDIC vector
    function automatic t_cordic_lane lane_init(input logic [31:0] phase);
        t_cordic_lane l;
        l.q = 2'(phase[31:30] + {1'b0, phase[29]});
        l.z = Z_W'($signed(phase[29:0]));
        l.x = GAIN_Q30;
        l.y = '0;
        return l;
    endfunction

    // Clamp a CORDIC output to plus or minus one in Q2.30
    function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
        if (v > 33'sd1073741824) begin
            return 32'sd1073741824;
        end else if (v < -33'sd1073741824) begin
            return -32'sd1073741824;
        end
        return v[UNIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/usvg_div_cell.sv
// One cell of the divider chain: one quotient bit for the stack and sector lanes.
// Depends on usvg_pkg.
`default_nettype none

module usvg_div_cell
    import usvg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_beat        i_beat,
    input  wire logic [CNT_W-1:0] i_stack_count,
    input  wire logic [CNT_W-1:0] i_sector_count,
    output t_div_beat             o_beat
);

    t_div_beat r_beat;
    t_div_beat n_beat;

    // Take one step on each lane
    always_comb begin
        n_beat          = i_beat;
        n_beat.stk      = div_step(i_beat.stk, i_stack_count);
        n_beat.sec      = div_step(i_beat.sec, i_sector_count);
    end

    // Hold the beat valid bit under reset, advance the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.in_range <= n_beat.in_range;
        r_beat.stk      <= n_beat.stk;
        r_beat.sec      <= n_beat.sec;
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

### hdl/usvg_cordic_cell.sv
// One CORDIC rotation cell for the stack and sector angles, with side data.
// Depends on usvg_pkg.
`default_nettype none

module usvg_cordic_cell
    import usvg_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cordic_beat i_beat,
    output t_cordic_beat      o_beat
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'($signed({1'b0, ATAN_TURNS[STEP]}));

    function automatic t_cordic_lane rotate(input t_cordic_lane l);
        t_cordic_lane r;
        r = l;
        if (!l.z[Z_W-1]) begin
            r.x = l.x - (l.y >>> STEP);
            r.y = l.y + (l.x >>> STEP);
            r.z = l.z - ATAN;
        end else begin
            r.x = l.x + (l.y >>> STEP);
            r.y = l.y - (l.x >>> STEP);
            r.z = l.z + ATAN;
        end
        return r;
    endfunction

    t_cordic_beat r_beat;
    t_cordic_beat n_beat;

    // Rotate both lanes towards zero residual angle
    always_comb begin
        n_beat   = i_beat;
        n_beat.u = rotate(i_beat.u);
        n_beat.v = rotate(i_beat.v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.in_range <= n_beat.in_range;
        r_beat.tex_s    <= n_beat.tex_s;
        r_beat.tex_t    <= n_beat.tex_t;
        r_beat.u        <= n_beat.u;
        r_beat.v        <= n_beat.v;
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

### hdl/uv_sphere_vertex_generator.sv
// Top level of the UV-sphere vertex generator: config registers, divider and
// CORDIC cell chains, products and output stage. Depends on usvg_pkg and cells.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  input   | i_start, o_busy           | i_stack_index, i_sector_index
//  result  | o_valid (strobe)          | o_pos_*, o_norm_*, o_tex_s/t, o_in_range
//  config  | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One index pair is taken every cycle; o_busy stays low.
// A pair passes through the 17-cell divider chain, phase prep, the CORDIC cell
// chain, quadrant rotation and two multiply stages, each followed by rounding.
// Synchronous active-low reset clears all beat valid bits and loads the
// register defaults (36 sectors, 18 stacks, radius 1.0). The result strobe
// lasts one cycle and cannot be held off.
`default_nettype none

module uv_sphere_vertex_generator
    import usvg_pkg::*;
#(
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    output logic                         o_busy,
    input  wire logic [CNT_W-1:0]        i_stack_index,
    input  wire logic [CNT_W-1:0]        i_sector_index,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [RAD_W-1:0]        i_cfg_data,
    output logic                         o_valid,
    output logic signed [POS_W-1:0]      o_pos_x,
    output logic signed [POS_W-1:0]      o_pos_y,
    output logic signed [POS_W-1:0]      o_pos_z,
    output logic signed [NRM_W-1:0]      o_norm_x,
    output logic signed [NRM_W-1:0]      o_norm_y,
    output logic signed [NRM_W-1:0]      o_norm_z,
    output logic [TEX_W-1:0]             o_tex_s,
    output logic [TEX_W-1:0]             o_tex_t,
    output logic                         o_in_range
);

    localparam logic [31:0] MAX_DIV = 32'(MAX_DIVISIONS);
    localparam int LATENCY = DIV_STEPS + CORDIC_STEPS + 6;
    localparam logic signed [63:0] HALF30 = 64'sd536870912;
    localparam logic signed [48:0] HALF30_P = 49'sd536870912;
    localparam logic signed [UNIT_W-1:0] HALF16 = 32'sd32768;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic [TEX_W-1:0] tex_s;
        logic [TEX_W-1:0] tex_t;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0] r_sector_count;
    logic [CNT_W-1:0] r_stack_count;
    logic [RAD_W-1:0] r_sphere_radius;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count  <= CNT_W'(36);
            r_stack_count   <= CNT_W'(18);
            r_sphere_radius <= RAD_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SECTOR_COUNT:  r_sector_count  <= i_cfg_data[CNT_W-1:0];
                CFG_STACK_COUNT:   r_stack_count   <= i_cfg_data[CNT_W-1:0];
                CFG_SPHERE_RADIUS: r_sphere_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input beat and divider chain ----------------
    logic      w_accept;
    logic      w_in_range;
    t_div_beat w_db [DIV_STEPS+1];

    assign w_accept   = i_start && !o_busy;
    assign w_in_range = (r_sector_count != '0) && (r_stack_count != '0)
                     && ({21'b0, r_sector_count} <= MAX_DIV)
                     && ({21'b0, r_stack_count} <= MAX_DIV)
                     && (i_stack_index <= r_stack_count)
                     && (i_sector_index <= r_sector_count);

    // Numerator is index * 65536 + count / 2; its top ten bits seed the remainder
    always_comb begin
        w_db[0].valid    = w_accept;
        w_db[0].in_range = w_in_range;
        w_db[0].stk.rem  = {1'b0, i_stack_index[CNT_W-1:1]};
        w_db[0].stk.nq   = {i_stack_index[0], 6'b0, r_stack_count[CNT_W-1:1]};
        w_db[0].sec.rem  = {1'b0, i_sector_index[CNT_W-1:1]};
        w_db[0].sec.nq   = {i_sector_index[0], 6'b0, r_sector_count[CNT_W-1:1]};
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        usvg_div_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_beat         (w_db[g]),
            .i_stack_count  (r_stack_count),
            .i_sector_count (r_sector_count),
            .o_beat         (w_db[g+1])
        );
    end

    // ---------------- phase preparation ----------------
    t_cordic_beat r_prep;
    t_cordic_beat n_prep;
    logic [31:0]  w_phase_u;
    logic [31:0]  w_phase_v;

    always_comb begin
        w_phase_v       = {w_db[DIV_STEPS].sec.nq[15:0], 16'b0};
        w_phase_u       = 32'h4000_0000 - {w_db[DIV_STEPS].stk.nq, 15'b0};
        n_prep.valid    = w_db[DIV_STEPS].valid;
        n_prep.in_range = w_db[DIV_STEPS].in_range;
        n_prep.tex_s    = w_db[DIV_STEPS].sec.nq;
        n_prep.tex_t    = w_db[DIV_STEPS].stk.nq;
        n_prep.u        = lane_init(w_phase_u);
        n_prep.v        = lane_init(w_phase_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else begin
            r_prep.valid <= n_prep.valid;
        end
        r_prep.in_range <= n_prep.in_range;
        r_prep.tex_s    <= n_prep.tex_s;
        r_prep.tex_t    <= n_prep.tex_t;
        r_prep.u        <= n_prep.u;
        r_prep.v        <= n_prep.v;
    end

    // ---------------- CORDIC chain ----------------
    t_cordic_beat w_cb [CORDIC_STEPS+1];

    assign w_cb[0] = r_prep;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        usvg_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_cb[g]),
            .o_beat  (w_cb[g+1])
        );
    end

    // ---------------- clamp and quadrant rotation ----------------
    t_side                     r_rot_side;
    logic signed [UNIT_W-1:0]  r_cu, r_su, r_cv, r_sv;
    logic signed [UNIT_W-1:0]  n_cu, n_su, n_cv, n_sv;
    logic signed [UNIT_W-1:0]  w_xu, w_yu, w_xv, w_yv;

    always_comb begin
        w_xu = clamp_unit(w_cb[CORDIC_STEPS].u.x);
        w_yu = clamp_unit(w_cb[CORDIC_STEPS].u.y);
        w_xv = clamp_unit(w_cb[CORDIC_STEPS].v.x);
        w_yv = clamp_unit(w_cb[CORDIC_STEPS].v.y);
        unique case (w_cb[CORDIC_STEPS].u.q)
            2'd0:    begin n_cu = w_xu;  n_su = w_yu;  end
            2'd1:    begin n_cu = -w_yu; n_su = w_xu;  end
            2'd2:    begin n_cu = -w_xu; n_su = -w_yu; end
            default: begin n_cu = w_yu;  n_su = -w_xu; end
        endcase
        unique case (w_cb[CORDIC_STEPS].v.q)
            2'd0:    begin n_cv = w_xv;  n_sv = w_yv;  end
            2'd1:    begin n_cv = -w_yv; n_sv = w_xv;  end
            2'd2:    begin n_cv = -w_xv; n_sv = -w_yv; end
            default: begin n_cv = w_yv;  n_sv = -w_xv; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_side.valid <= 1'b0;
        end else begin
            r_rot_side.valid <= w_cb[CORDIC_STEPS].valid;
        end
        r_rot_side.in_range <= w_cb[CORDIC_STEPS].in_range;
        r_rot_side.tex_s    <= w_cb[CORDIC_STEPS].tex_s;
        r_rot_side.tex_t    <= w_cb[CORDIC_STEPS].tex_t;
        r_cu <= n_cu;
        r_su <= n_su;
        r_cv <= n_cv;
        r_sv <= n_sv;
    end

    // ---------------- cosU * cosV, cosU * sinV ----------------
    t_side                    r_m1_side;
    logic signed [63:0]       r_pux, r_puy;
    logic signed [UNIT_W-1:0] r_m1_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_side.valid <= 1'b0;
        end else begin
            r_m1_side.valid <= r_rot_side.valid;
        end
        r_m1_side.in_range <= r_rot_side.in_range;
        r_m1_side.tex_s    <= r_rot_side.tex_s;
        r_m1_side.tex_t    <= r_rot_side.tex_t;
        r_pux   <= r_cu * r_cv;
        r_puy   <= r_cu * r_sv;
        r_m1_uz <= r_su;
    end

    // ---------------- round to Q2.30 unit vector ----------------
    t_side                    r_un_side;
    logic signed [UNIT_W-1:0] r_ux, r_uy, r_uz;
    logic signed [63:0]       w_rx, w_ry;

    assign w_rx = (r_pux + HALF30) >>> 30;
    assign w_ry = (r_puy + HALF30) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_un_side.valid <= 1'b0;
        end else begin
            r_un_side.valid <= r_m1_side.valid;
        end
        r_un_side.in_range <= r_m1_side.in_range;
        r_un_side.tex_s    <= r_m1_side.tex_s;
        r_un_side.tex_t    <= r_m1_side.tex_t;
        r_ux <= w_rx[UNIT_W-1:0];
        r_uy <= w_ry[UNIT_W-1:0];
        r_uz <= r_m1_uz;
    end

    // ---------------- radius products and normals ----------------
    t_side                    r_m2_side;
    logic signed [48:0]       r_ppx, r_ppy, r_ppz;
    logic signed [NRM_W-1:0]  r_nx, r_ny, r_nz;
    logic signed [RAD_W:0]    w_rad;
    logic signed [UNIT_W-1:0] w_nx, w_ny, w_nz;

    assign w_rad = $signed({1'b0, r_sphere_radius});
    assign w_nx  = (r_ux + HALF16) >>> 16;
    assign w_ny  = (r_uy + HALF16) >>> 16;
    assign w_nz  = (r_uz + HALF16) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_side.valid <= 1'b0;
        end else begin
            r_m2_side.valid <= r_un_side.valid;
        end
        r_m2_side.in_range <= r_un_side.in_range;
        r_m2_side.tex_s    <= r_un_side.tex_s;
        r_m2_side.tex_t    <= r_un_side.tex_t;
        r_ppx <= w_rad * r_ux;
        r_ppy <= w_rad * r_uy;
        r_ppz <= w_rad * r_uz;
        r_nx  <= w_nx[NRM_W-1:0];
        r_ny  <= w_ny[NRM_W-1:0];
        r_nz  <= w_nz[NRM_W-1:0];
    end

    // Output stage: round positions, zero the fields of out-of-range results
    logic signed [48:0] w_px, w_py, w_pz;
    logic               w_keep;

    assign w_px   = (r_ppx + HALF30_P) >>> 30;
    assign w_py   = (r_ppy + HALF30_P) >>> 30;
    assign w_pz   = (r_ppz + HALF30_P) >>> 30;
    assign w_keep = r_m2_side.in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_m2_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_pos_x    <= w_keep ? w_px[POS_W-1:0] : '0;
        o_pos_y    <= w_keep ? w_py[POS_W-1:0] : '0;
        o_pos_z    <= w_keep ? w_pz[POS_W-1:0] : '0;
        o_norm_x   <= w_keep ? r_nx : '0;
        o_norm_y   <= w_keep ? r_ny : '0;
        o_norm_z   <= w_keep ? r_nz : '0;
        o_tex_s    <= w_keep ? r_m2_side.tex_s : '0;
        o_tex_t    <= w_keep ? r_m2_side.tex_t : '0;
        o_in_range <= w_keep;
    end

`ifndef NO_ASSERTIONS
    // Every accepted pair gives a result after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result missing after accepted beat");

    // No result appears without an accepted pair
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without a matching accepted beat");

    // Out-of-range results carry zeros
    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_tex_s == '0 && o_tex_t == '0
            && o_pos_x == '0 && o_norm_z == '0))
        else $error("out-of-range result not zeroed");

    // The x and z normal components stay within the unit range
    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_z <= 16'sd16384 && o_norm_z >= -16'sd16384
            && o_norm_x <= 16'sd16384 && o_norm_x >= -16'sd16384))
        else $error("normal component outside unit range");
`endif

endmodule

`default_nettype wire

### tb/usvg_checker.sv
// Vertex checker: watches the config, index and result channels of the UV-sphere
// vertex generator, predicts each vertex and compares it. Depends on usvg_pkg.
module usvg_checker
    import usvg_pkg::*;
#(
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [CNT_W-1:0]       i_stack_index,
    input  logic [CNT_W-1:0]       i_sector_index,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [RAD_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [NRM_W-1:0] i_norm_x,
    input  logic signed [NRM_W-1:0] i_norm_y,
    input  logic signed [NRM_W-1:0] i_norm_z,
    input  logic [TEX_W-1:0]       i_tex_s,
    input  logic [TEX_W-1:0]       i_tex_t,
    input  logic                   i_in_range,
    output int                     o_pending,
    output int                     o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
        logic signed [NRM_W-1:0] norm_x, norm_y, norm_z;
        logic [TEX_W-1:0]        tex_s, tex_t;
        logic                    in_range;
    } t_vertex;

    t_vertex          vertex_q[$];
    logic [CNT_W-1:0] sectors, stacks;
    logic [RAD_W-1:0] radius;
    int               mismatches;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // Quadrant fold, CORDIC rotation on the residual angle, then clamp and quadrant rotation
    function automatic void phase_sincos(input logic [31:0] phase,
                                         output longint c, output longint s);
        logic [31:0] quad, d;
        longint      x, y, z, nx, ny;
        quad = ((phase + 32'h2000_0000) >> 30) & 32'd3;
        d = phase - (quad << 30);
        z = longint'($signed(d));
        x = longint'(GAIN_Q30);
        y = 0;
        for (int k = 0; k < CORDIC_STEPS && k < ATAN_ENTRIES; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z -= longint'(ATAN_TURNS[k]);
            end else begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z += longint'(ATAN_TURNS[k]);
            end
            x = nx;
            y = ny;
        end
        x = clamp_one(x);
        y = clamp_one(y);
        case (quad[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_vertex vertex_predict(logic [CNT_W-1:0] stk, logic [CNT_W-1:0] sec);
        t_vertex     v;
        logic [31:0] ts, tt;
        longint      cu, su, cv, sv, ux, uy, uz, r;
        v = '0;
        if (sectors == 0 || stacks == 0 || sectors > MAX_DIVISIONS ||
            stacks > MAX_DIVISIONS || stk > stacks || sec > sectors)
            return v;
        ts = (32'(sec) * 32'd65536 + 32'(sectors) / 2) / 32'(sectors);
        tt = (32'(stk) * 32'd65536 + 32'(stacks) / 2) / 32'(stacks);
        phase_sincos(32'h4000_0000 - (tt << 15), cu, su);
        phase_sincos(ts << 16, cv, sv);
        ux = rnd_shift(cu * cv, 30);
        uy = rnd_shift(cu * sv, 30);
        uz = su;
        r  = longint'(radius);
        v.pos_x  = POS_W'(rnd_shift(r * ux, 30));
        v.pos_y  = POS_W'(rnd_shift(r * uy, 30));
        v.pos_z  = POS_W'(rnd_shift(r * uz, 30));
        v.norm_x = NRM_W'(rnd_shift(ux, 16));
        v.norm_y = NRM_W'(rnd_shift(uy, 16));
        v.norm_z = NRM_W'(rnd_shift(uz, 16));
        v.tex_s  = TEX_W'(ts);
        v.tex_t  = TEX_W'(tt);
        v.in_range = 1'b1;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_vertex got, want;
        if (!i_rst_n) begin
            sectors <= 11'd36;
            stacks  <= 11'd18;
            radius  <= 16'd256;
            vertex_q.delete();
            o_pending  <= 0;
            o_errors   <= 0;
            mismatches <= 0;
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SECTOR_COUNT:  sectors <= i_cfg_data[CNT_W-1:0];
                    CFG_STACK_COUNT:   stacks  <= i_cfg_data[CNT_W-1:0];
                    CFG_SPHERE_RADIUS: radius  <= i_cfg_data;
                    default: ;
                endcase
            end
            // Predict each accepted index beat
            if (i_start && !i_busy)
                vertex_q.push_back(vertex_predict(i_stack_index, i_sector_index));
            // Compare each result beat with the oldest prediction
            if (i_valid) begin
                got = '{i_pos_x, i_pos_y, i_pos_z, i_norm_x, i_norm_y, i_norm_z,
                        i_tex_s, i_tex_t, i_in_range};
                if (vertex_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (mismatches < 10)
                        $display("unexpected result beat at %0t", $realtime);
                    mismatches <= mismatches + 1;
                end else begin
                    want = vertex_q.pop_front();
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                        if (mismatches < 10) begin
                            $display("mismatch at %0t: exp pos %0d %0d %0d nrm %0d %0d %0d",
                                $realtime, want.pos_x, want.pos_y, want.pos_z,
                                want.norm_x, want.norm_y, want.norm_z,
                                " tex %0d %0d ok %0b", want.tex_s, want.tex_t,
                                want.in_range);
                            $display("    got pos %0d %0d %0d nrm %0d %0d %0d",
                                got.pos_x, got.pos_y, got.pos_z,
                                got.norm_x, got.norm_y, got.norm_z,
                                " tex %0d %0d ok %0b", got.tex_s, got.tex_t,
                                got.in_range);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            o_pending <= vertex_q.size();
        end
    end
endmodule

### tb/tb_uv_sphere_vertex_generator.sv
// Testbench top: drives index beats and register writes into the UV-sphere
// vertex generator and gives the verdict. Depends on usvg_pkg and usvg_checker.
module tb_uv_sphere_vertex_generator
    import usvg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = DIV_STEPS + CORDIC_STEPS_DEF + 6;
    localparam int LIMIT   = 400000;
    localparam logic [1:0] CFG_UNKNOWN = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic [CNT_W-1:0]        i_stack_index = '0;
    logic [CNT_W-1:0]        i_sector_index = '0;
    logic                    i_cfg_valid = 1'b0;
    logic [1:0]              i_cfg_index = CFG_SECTOR_COUNT;
    logic [RAD_W-1:0]        i_cfg_data = '0;
    logic                    o_busy, o_cfg_ready, o_valid, o_in_range;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [NRM_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic [TEX_W-1:0]        o_tex_s, o_tex_t;
    int                      pending, errors;
    int                      cycles = 0;
    int                      cur_sectors, cur_stacks;

    always #5 i_clk = ~i_clk;

    uv_sphere_vertex_generator u_top (.*);

    usvg_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_stack_index, .i_sector_index,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_valid(o_valid), .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_pos_z(o_pos_z),
        .i_norm_x(o_norm_x), .i_norm_y(o_norm_y), .i_norm_z(o_norm_z),
        .i_tex_s(o_tex_s), .i_tex_t(o_tex_t), .i_in_range(o_in_range),
        .o_pending(pending), .o_errors(errors)
    );

    // Abort on a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[uv_sphere_vertex_generator] ERROR");
            $finish;
        end
    end

    // Write one register; valid is dropped afterwards
    task automatic reg_write(logic [1:0] idx, logic [RAD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SECTOR_COUNT) cur_sectors = data[CNT_W-1:0];
        if (idx == CFG_STACK_COUNT)  cur_stacks  = data[CNT_W-1:0];
    endtask

    // Hold until every prediction has been met, then let the pipe drain
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_counts(int sec, int stk, int rad);
        drain();
        reg_write(CFG_SECTOR_COUNT, RAD_W'(sec));
        reg_write(CFG_STACK_COUNT, RAD_W'(stk));
        reg_write(CFG_SPHERE_RADIUS, RAD_W'(rad));
    endtask

    // Send one index beat; start stays high inside a burst
    task automatic send_beat(int stk, int sec, bit last_in_burst, int gap);
        i_start        <= 1'b1;
        i_stack_index  <= CNT_W'(stk);
        i_sector_index <= CNT_W'(sec);
        do @(posedge i_clk); while (o_busy);
        if (last_in_burst && gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_idle(int stk, int sec);
        send_beat(stk, sec, 1'b1, 1);
    endtask

    // Random phase: mostly in-range pairs, some arbitrary noise
    task automatic random_items(int n);
        int left, gap, stk, sec;
        bit steady;
        left = 0;
        steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            if (left == 0) left = $urandom_range(1, 24);
            left--;
            if ($urandom_range(0, 9) == 0) begin
                stk = $urandom_range(0, 2047);
                sec = $urandom_range(0, 2047);
            end else begin
                stk = (cur_stacks == 0) ? 0 : $urandom_range(0, cur_stacks);
                sec = (cur_sectors == 0) ? 0 : $urandom_range(0, cur_sectors);
            end
            gap = steady ? 0 : $urandom_range(1, 8);
            send_beat(stk, sec, left == 0 || k == n - 1, (k == n - 1) ? 1 : gap);
        end
    endtask

    initial begin
        int sec, stk;
        cur_sectors = 36;
        cur_stacks = 18;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: poles, seam, just beyond, all-ones indices
        send_idle(0, 0);
        send_idle(18, 36);
        send_idle(9, 18);
        send_idle(19, 0);
        send_idle(0, 37);
        send_idle(2047, 2047);
        // Unknown register index must be ignored
        drain();
        reg_write(CFG_UNKNOWN, 16'hFFFF);
        send_idle(5, 7);
        // Smallest counts and radius
        set_counts(1, 1, 1);
        send_idle(0, 0);
        send_idle(1, 1);
        send_idle(0, 1);
        send_idle(2, 0);
        // Largest counts and radius
        set_counts(1024, 1024, 65535);
        send_idle(0, 0);
        send_idle(1024, 1024);
        send_idle(512, 256);
        send_idle(1025, 1024);
        send_idle(1024, 1025);
        // Zero counts, counts beyond the maximum, zero radius
        set_counts(0, 18, 256);
        send_idle(0, 0);
        set_counts(36, 0, 256);
        send_idle(0, 0);
        set_counts(1025, 2047, 256);
        send_idle(0, 0);
        send_idle(3, 3);
        set_counts(36, 18, 0);
        send_idle(4, 9);
        send_idle(18, 36);

        // Random phases, extremes among them
        random_items(150);
        set_counts(1024, 1024, 65535);
        random_items(150);
        set_counts(1, 1, 1);
        random_items(100);
        for (int p = 0; p < 7; p++) begin
            sec = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                              : $urandom_range(1, 64);
            stk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                              : $urandom_range(1, 64);
            if (p == 6) begin
                sec = $urandom_range(1025, 2047);
                stk = $urandom_range(0, 2047);
            end
            set_counts(sec, stk, $urandom_range(0, 65535));
            random_items(155);
        end

        i_start <= 1'b0;
        drain();
        if (errors == 0 && pending == 0) begin
            $display("[uv_sphere_vertex_generator] OK");
        end else begin
            $display("[uv_sphere_vertex_generator] ERROR");
        end
        $finish;
    end
endmodule
